// File: rtl/ctc_pkg.sv
// shared types, constants and divisor tables for the ctc prescaler search
package ctc_pkg;

   localparam int unsigned FreqW     = 32;
   localparam int unsigned TimerW    = 3;
   localparam int unsigned PrescaleW = 11;
   localparam int unsigned SelectW   = 3;
   localparam int unsigned CompareW  = 16;
   localparam int unsigned ShiftW    = 4;
   localparam int unsigned CandW     = 3;
   localparam int unsigned DivSteps  = 32;
   localparam int unsigned DivCntW   = 5;

   localparam logic [FreqW-1:0]  CpuFreqReset = 32'd16000000;
   localparam logic [TimerW-1:0] Timer0       = 3'd0;
   localparam logic [TimerW-1:0] Timer2       = 3'd2;
   localparam logic [CandW-1:0]  CandLastT2   = 3'd6;
   localparam logic [CandW-1:0]  CandLastStd  = 3'd4;

   // command word from controller to datapath
   typedef struct packed {
      logic             start;
      logic             div_step;
      logic             commit;
      logic [CandW-1:0] cand;
   } ctc_cmd_type;

   // status word from datapath to controller
   typedef struct packed {
      logic hit;
      logic last;
   } ctc_status_type;

   // log2 of the prescaler at a list position
   function automatic logic [ShiftW-1:0] cand_log2(input logic is_t2,
                                                   input logic [CandW-1:0] idx);
      logic [ShiftW-1:0] res;
      res = '0;
      if (is_t2) begin
         unique case (idx)
            3'd0:    res = 4'd0;
            3'd1:    res = 4'd3;
            3'd2:    res = 4'd5;
            3'd3:    res = 4'd6;
            3'd4:    res = 4'd7;
            3'd5:    res = 4'd8;
            3'd6:    res = 4'd10;
            default: res = 4'd10;
         endcase
      end else begin
         unique case (idx)
            3'd0:    res = 4'd0;
            3'd1:    res = 4'd3;
            3'd2:    res = 4'd6;
            3'd3:    res = 4'd8;
            3'd4:    res = 4'd10;
            default: res = 4'd10;
         endcase
      end
      return res;
   endfunction

endpackage

// File: rtl/ctc_req_if.sv
// request channel interface: desired frequency and timer number
interface ctc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] desired_freq;
   logic [2:0]  timer_index;

   modport source (output valid, output desired_freq, output timer_index, input ready);
   modport sink   (input valid, input desired_freq, input timer_index, output ready);
endinterface

// File: rtl/ctc_rsp_if.sv
// response channel interface: chosen prescaler and compare value
interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [10:0] prescale;
   logic [2:0]  clock_select;
   logic [15:0] compare_value;

   modport source (output valid, output found, output prescale, output clock_select,
                   output compare_value, input ready);
   modport sink   (input valid, input found, input prescale, input clock_select,
                   input compare_value, output ready);
endinterface

// File: rtl/ctc_ctrl.sv
// controller: sequences the divide, the prescaler scan and the output word
module ctc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ctc_pkg::ctc_cmd_type    cmd,
   input  ctc_pkg::ctc_status_type status
);
   import ctc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

   state_type          state_ff, state_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [CandW-1:0]   cand_ff, cand_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               slot_free;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.cand     = cand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               cand_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.last) begin
               if (slot_free) begin
                  cmd.commit   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_start_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIV) && (cnt_ff == '0))
      else $error("divide did not start after accept");

   a_div_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DivLast) |=> (state_ff == ST_SCAN) && (cand_ff == '0))
      else $error("scan did not follow the last divide step");

   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (state_ff == ST_SCAN) && (status.hit || status.last) && slot_free)
      else $error("result committed out of turn");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("committed result not presented");

endmodule

// File: rtl/ctc_dp.sv
// datapath: cpu clock register, bit-serial divider, candidate check, result register
module ctc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ctc_pkg::FreqW-1:0]           csr_wr_data,
   input  logic [ctc_pkg::FreqW-1:0]           req_desired_freq,
   input  logic [ctc_pkg::TimerW-1:0]          req_timer_index,
   input  ctc_pkg::ctc_cmd_type                cmd,
   output ctc_pkg::ctc_status_type             status,
   output logic                                rsp_found,
   output logic [ctc_pkg::PrescaleW-1:0]       rsp_prescale,
   output logic [ctc_pkg::SelectW-1:0]         rsp_clock_select,
   output logic [ctc_pkg::CompareW-1:0]        rsp_compare_value
);
   import ctc_pkg::*;

   logic [FreqW-1:0]     cpu_freq_ff;
   logic [FreqW-1:0]     freq_ff;
   logic [TimerW-1:0]    timer_ff;
   logic [FreqW-1:0]     rem_ff, rem_in;
   logic [FreqW-1:0]     quo_ff, quo_in;
   logic [FreqW:0]       trial;
   logic [FreqW:0]       diff;
   logic                 is_t2, is_8bit, freq_zero;
   logic [ShiftW-1:0]    log2p;
   logic [FreqW-1:0]     q;
   logic                 fits;
   logic                 found_ff;
   logic [PrescaleW-1:0] prescale_ff;
   logic [SelectW-1:0]   select_ff;
   logic [CompareW-1:0]  compare_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_freq_ff <= CpuFreqReset;
      end else if (csr_wr_en) begin
         cpu_freq_ff <= csr_wr_data;
      end
   end

   // restoring divide, one quotient bit per step
   assign trial = {rem_ff, quo_ff[FreqW-1]};
   assign diff  = trial - {1'b0, freq_ff};

   always_comb begin
      if (!diff[FreqW]) begin
         rem_in = diff[FreqW-1:0];
         quo_in = {quo_ff[FreqW-2:0], 1'b1};
      end else begin
         rem_in = trial[FreqW-1:0];
         quo_in = {quo_ff[FreqW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         freq_ff  <= req_desired_freq;
         timer_ff <= req_timer_index;
         rem_ff   <= '0;
         quo_ff   <= cpu_freq_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // cpu/(2*f*p) equals (cpu/f) >> (log2 p + 1)
   assign is_t2     = (timer_ff == Timer2);
   assign is_8bit   = (timer_ff == Timer0) || is_t2;
   assign freq_zero = (freq_ff == '0);
   assign log2p     = cand_log2(is_t2, cmd.cand);
   assign q         = quo_ff >> (log2p + 1'b1);

   // compare = q - 1 must stay below the timer's top value
   always_comb begin
      if (is_8bit) begin
         fits = (q[FreqW-1:8] == '0);
      end else begin
         fits = (q[FreqW-1:CompareW] == '0);
      end
   end

   assign status.hit  = !freq_zero && (q[FreqW-1:1] != '0) && fits;
   assign status.last = (cmd.cand == (is_t2 ? CandLastT2 : CandLastStd));

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         found_ff <= status.hit;
         if (status.hit) begin
            prescale_ff <= PrescaleW'(1) << log2p;
            select_ff   <= cmd.cand + 1'b1;
            compare_ff  <= q[CompareW-1:0] - 1'b1;
         end else begin
            prescale_ff <= '0;
            select_ff   <= '0;
            compare_ff  <= '0;
         end
      end
   end

   assign rsp_found         = found_ff;
   assign rsp_prescale      = prescale_ff;
   assign rsp_clock_select  = select_ff;
   assign rsp_compare_value = compare_ff;

endmodule

// File: rtl/ctc_prescaler_compare_search_top.sv
// top level of the ctc prescaler and compare value search
//
// req_ch carries one word per search: desired_freq in hertz and timer_index.
// timers 0 and 2 are 8-bit, all others 16-bit; timer 2 has seven prescalers
// (1,8,32,64,128,256,1024), the rest five (1,8,64,256,1024).
// rsp_ch returns one word per request: found, prescale, clock_select and
// compare_value, all zero when no prescaler fits or the frequency is zero.
// csr_wr_en/csr_wr_data load cpu_freq; write it only while the block is idle.
//
// the bit-serial divider first computes cpu_freq / desired_freq; the scan
// then tries one prescaler per cycle (1 to 7 of them) until one fits or the
// list ends, and the response word is registered from that prescaler.
// the divider is shared by all candidates; each prescaler is a right shift
// of its quotient. one search runs at a time; req_ch.ready is high only
// between searches, so a new request is taken only after the last search has committed.
// a finished word sits in the output register; a new request is accepted
// while it waits. a further result holds in the scan until rsp_ch drains.
// reset clears all control state and sets cpu_freq to 16 MHz.
module ctc_prescaler_compare_search_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ctc_pkg::FreqW-1:0] csr_wr_data,
   ctc_req_if.sink                   req_ch,
   ctc_rsp_if.source                 rsp_ch
);
   import ctc_pkg::*;

   ctc_cmd_type    cmd;
   ctc_status_type status;

   // sequencing: idle, divide, scan
   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and result register
   ctc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_desired_freq  (req_ch.desired_freq),
      .req_timer_index   (req_ch.timer_index),
      .cmd               (cmd),
      .status            (status),
      .rsp_found         (rsp_ch.found),
      .rsp_prescale      (rsp_ch.prescale),
      .rsp_clock_select  (rsp_ch.clock_select),
      .rsp_compare_value (rsp_ch.compare_value)
   );

endmodule

// File: tb/tb_ctc_prescaler_compare_search_top.sv
// testbench for the ctc prescaler and compare value search, with its own result predictor
`timescale 1ns / 1ps

module tb_ctc_prescaler_compare_search_top;
   import ctc_pkg::*;

   // one response word as the block returns it
   typedef struct packed {
      logic                 found;
      logic [PrescaleW-1:0] prescale;
      logic [SelectW-1:0]   clock_select;
      logic [CompareW-1:0]  compare_value;
   } ctc_result_type;

   // keeps a copy of cpu_freq, predicts the word for every accepted request
   // and checks the returned words in order
   class compare_search_tracker;
      logic [FreqW-1:0] cpu_freq;
      ctc_result_type   awaited[$];
      int unsigned      mismatches;

      function new();
         cpu_freq   = CpuFreqReset;
         mismatches = 0;
      endfunction

      // divisor at a list position; timer 2 has the longer list
      static function int unsigned divisor_at(logic is_t2, int unsigned pos);
         int unsigned d;
         d = 1024;
         if (is_t2) begin
            case (pos)
               0:       d = 1;
               1:       d = 8;
               2:       d = 32;
               3:       d = 64;
               4:       d = 128;
               5:       d = 256;
               default: d = 1024;
            endcase
         end else begin
            case (pos)
               0:       d = 1;
               1:       d = 8;
               2:       d = 64;
               3:       d = 256;
               default: d = 1024;
            endcase
         end
         return d;
      endfunction

      static function int unsigned list_len(logic is_t2);
         return is_t2 ? 7 : 5;
      endfunction

      // compare must stay strictly below this; timers 0 and 2 are 8-bit
      static function int unsigned compare_top(logic [TimerW-1:0] timer);
         return (timer == Timer0 || timer == Timer2) ? 32'hff : 32'hffff;
      endfunction

      function ctc_result_type pick_prescaler(logic [FreqW-1:0] freq, logic [TimerW-1:0] timer);
         ctc_result_type    res;
         logic              is_t2;
         longint unsigned   top;
         longint unsigned   prod;
         longint unsigned   quot;
         int unsigned       pos;
         bit                done;
         res   = '0;
         is_t2 = (timer == Timer2);
         top   = 64'(compare_top(timer));
         done  = 1'b0;
         if (freq != '0) begin
            for (pos = 0; pos < list_len(is_t2) && !done; pos++) begin
               // exact product, up to 43 bits
               prod = 64'(freq) * 64'd2 * 64'(divisor_at(is_t2, pos));
               quot = 64'(cpu_freq) / prod;
               if (quot >= 2 && (quot - 1) < top) begin
                  res.found         = 1'b1;
                  res.prescale      = PrescaleW'(divisor_at(is_t2, pos));
                  res.clock_select  = SelectW'(pos + 1);
                  res.compare_value = CompareW'(quot - 1);
                  done              = 1'b1;
               end
            end
         end
         return res;
      endfunction

      function void note_request(logic [FreqW-1:0] freq, logic [TimerW-1:0] timer);
         awaited.push_back(pick_prescaler(freq, timer));
      endfunction

      function void check_response(ctc_result_type got);
         ctc_result_type want;
         if (awaited.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            mismatches++;
         end
         if (got.prescale !== want.prescale) begin
            $error("prescale: expected %0d, actual %0d", want.prescale, got.prescale);
            mismatches++;
         end
         if (got.clock_select !== want.clock_select) begin
            $error("clock_select: expected %0d, actual %0d", want.clock_select,
                   got.clock_select);
            mismatches++;
         end
         if (got.compare_value !== want.compare_value) begin
            $error("compare_value: expected %0d, actual %0d", want.compare_value,
                   got.compare_value);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [FreqW-1:0] csr_wr_data;

   // cpu_freq as currently loaded, used to aim the stimulus
   logic [FreqW-1:0] cpu_now;
   // when set neither side idles
   bit               steady;

   compare_search_tracker tracker = new();

   ctc_req_if req_ch ();
   ctc_rsp_if rsp_ch ();

   ctc_prescaler_compare_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response side stalls about 28 percent of the time
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
   end

   // sample both channels at the rising edge; responses first, then requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_response({rsp_ch.found, rsp_ch.prescale, rsp_ch.clock_select,
                                    rsp_ch.compare_value});
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_request(req_ch.desired_freq, req_ch.timer_index);
         end
      end
   end

   // present one request word, with a random gap ahead of it, until taken
   task automatic send_search(input logic [FreqW-1:0] freq, input logic [TimerW-1:0] timer);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.desired_freq <= freq;
      req_ch.timer_index  <= timer;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // cpu_freq is only written with the block idle
   task automatic load_cpu_freq(input logic [FreqW-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tracker.cpu_freq = value;
      cpu_now          = value;
   endtask

   // one frequency per position of the timer's list, aimed at mid-range compare
   // so that the earlier, smaller divisors overflow and this one is chosen
   task automatic sweep_positions(input logic [TimerW-1:0] timer);
      logic            is_t2;
      int unsigned     pos;
      longint unsigned mid;
      is_t2 = (timer == Timer2);
      mid   = 64'((compare_search_tracker::compare_top(timer) + 1) / 2);
      for (pos = 0; pos < compare_search_tracker::list_len(is_t2); pos++) begin
         send_search(FreqW'(64'(cpu_now) /
                     (64'd2 * 64'(compare_search_tracker::divisor_at(is_t2, pos)) * mid)),
                     timer);
      end
   endtask

   // random frequency; most are aimed at a chosen divisor and compare value
   function automatic logic [FreqW-1:0] pick_freq(input logic [TimerW-1:0] timer);
      logic            is_t2;
      int unsigned     sel;
      int unsigned     pos;
      int unsigned     cmp;
      longint unsigned f;
      is_t2 = (timer == Timer2);
      sel   = $urandom_range(0, 99);
      if (sel < 60) begin
         pos = $urandom_range(0, compare_search_tracker::list_len(is_t2) - 1);
         cmp = $urandom_range(1, compare_search_tracker::compare_top(timer) - 1);
         f   = 64'(cpu_now) /
               (64'd2 * 64'(compare_search_tracker::divisor_at(is_t2, pos)) * 64'(cmp + 1));
         if (f == 0) f = 64'($urandom_range(1, 3));
         return FreqW'(f);
      end else if (sel < 78) begin
         return $urandom;
      end else if (sel < 88) begin
         return $urandom_range(1, 2000);
      end else if (sel < 95) begin
         // quotient of one to three at divisor 1: rejected, or compare of one or two
         return cpu_now / (2 * $urandom_range(1, 3));
      end else begin
         case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return 32'd1;
         endcase
      end
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned      n;
      logic [TimerW-1:0] timer;
      for (n = 0; n < count; n++) begin
         timer = TimerW'($urandom_range(0, 7));
         send_search(pick_freq(timer), timer);
      end
   endtask

   initial begin
      reset               = 1'b1;
      steady              = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      cpu_now             = CpuFreqReset;
      req_ch.valid        = 1'b0;
      req_ch.desired_freq = '0;
      req_ch.timer_index  = '0;
      rsp_ch.ready        = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset clock of 16 MHz
      send_search(32'd0, 3'd0);            // zero frequency, reported as not found
      send_search('1, 3'd1);               // largest frequency, quotient zero
      send_search(32'd1, 3'd0);            // 8-bit timer overflows every divisor
      send_search(32'd1, 3'd1);            // 16-bit timer, large divisor needed
      send_search(32'd1000, 3'd6);         // timer six behaves as 16-bit
      send_search(32'd100, 3'd7);          // timer seven as well
      send_search(32'd8000000, 3'd0);      // quotient one, rejected everywhere
      send_search(32'd4000000, 3'd0);      // quotient two, compare one
      send_search(32'd31250, 3'd0);        // quotient 256: compare 255 too big at 1
      sweep_positions(3'd0);
      sweep_positions(Timer2);
      run_random(180);
      drain();

      // fastest clock, no idling on either side for the whole phase
      load_cpu_freq('1);
      steady = 1'b1;
      sweep_positions(3'd1);
      run_random(180);
      drain();
      steady = 1'b0;

      // slowest nonzero clock: nothing can fit
      load_cpu_freq(32'd1);
      run_random(60);
      drain();

      // zero clock: every quotient is zero
      load_cpu_freq('0);
      run_random(40);
      drain();

      load_cpu_freq($urandom);
      run_random(200);
      drain();

      load_cpu_freq($urandom_range(1000000, 50000000));
      run_random(200);
      drain();

      load_cpu_freq(CpuFreqReset);
      run_random(170);
      drain();

      // let any stray word show up
      repeat (60) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("** ctc_prescaler_compare_search_top: PASSED **");
      end else begin
         $display("** ctc_prescaler_compare_search_top: FAILED **");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #5000000;
      $display("** ctc_prescaler_compare_search_top: FAILED **");
      $finish;
   end

endmodule
